// ===== hdl/spf_pkg.sv =====
// Shared types, constants and saturating helpers for the SPH force accumulator.
package spf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [2:0] {
    CFG_MASS       = 3'd0,
    CFG_INV_RADIUS = 3'd1,
    CFG_KP         = 3'd2,
    CFG_KV         = 3'd3,
    CFG_VISCOSITY  = 3'd4
  } cfg_idx_e;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  typedef struct packed {
    logic [30:0] mass;
    logic [30:0] inv_radius;
    logic [30:0] kp;
    logic [30:0] kv;
    logic [30:0] mu;
  } cfg_t;

  // one queued transaction, already classified
  typedef struct packed {
    logic               is_nbr;
    logic               last;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] pressure;
    logic [30:0]        density;
    logic [30:0]        distance;
  } item_t;

  typedef struct packed {
    logic signed [31:0] fpx;
    logic signed [31:0] fpy;
    logic signed [31:0] fvx;
    logic signed [31:0] fvy;
    logic               singular;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(MAX32)) r = MAX32;
    else if (v < 64'(MIN32)) r = MIN32;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == MIN32) r = MAX32;
    else r = -v;
    return r;
  endfunction

  function automatic logic signed [63:0] acc64(input logic signed [63:0] s,
                                               input logic signed [31:0] t);
    logic signed [64:0] sum;
    logic signed [63:0] r;
    sum = {s[63], s} + 65'(t);
    if (sum[64] != sum[63]) r = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = sum[63:0];
    return r;
  endfunction

endpackage

// ===== hdl/spf_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the back end.
module spf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic          func_i,
  input  logic [31:0]   pos_x_i,
  input  logic [31:0]   pos_y_i,
  input  logic [31:0]   vel_x_i,
  input  logic [31:0]   vel_y_i,
  input  logic [31:0]   pressure_i,
  input  logic [30:0]   density_i,
  input  logic [30:0]   distance_i,
  input  logic          last_i,
  output spf_pkg::item_t item_o,
  output logic          item_valid_o,
  input  logic          item_ready_i
);

  localparam int unsigned PW = $clog2(spf_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(spf_pkg::QUEUE_DEPTH + 1);

  spf_pkg::item_t mem_q [spf_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  spf_pkg::item_t in_item;
  logic           wr_en, rd_en;

  always_comb begin
    in_item.is_nbr   = func_i;
    in_item.last     = last_i;
    in_item.pos_x    = pos_x_i;
    in_item.pos_y    = pos_y_i;
    in_item.vel_x    = vel_x_i;
    in_item.vel_y    = vel_y_i;
    in_item.pressure = pressure_i;
    in_item.density  = in_item.is_nbr ? density_i : '0;
    in_item.distance = in_item.is_nbr ? distance_i : '0;
  end

  assign full         = (cnt_q == CW'(spf_pkg::QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= (wr_ptr_q == PW'(spf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= (rd_ptr_q == PW'(spf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (!wr_en && rd_en) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hdl/spf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module spf_div #(
  parameter int unsigned NUM_W = 47
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [30:0]      den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_q;
  logic [30:0]      rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [31:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, nq_q[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = nq_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? 31'(rem_sh - {1'b0, den_q}) : rem_sh[30:0];
      nq_q  <= {nq_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NUM_W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hdl/spf_back.sv =====
// Back end: sequences the force terms over a shared multiplier and divider.
module spf_back #(
  parameter int unsigned FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spf_pkg::cfg_t               cfg_i,
  input  spf_pkg::item_t              item_i,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  output logic                        div_start_o,
  output logic [31+FRAC_BITS-1:0]     div_num_o,
  output logic [30:0]                 div_den_o,
  input  logic                        div_done_i,
  input  logic [31+FRAC_BITS-1:0]     div_quo_i,
  output spf_pkg::result_t            res_o,
  output logic                        res_valid_o,
  input  logic                        res_pop_i
);

  localparam int unsigned NUM_W = 31 + FRAC_BITS;
  localparam logic [30:0] ONE31 = 31'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_WB   = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef enum logic [4:0] {
    S_Q, S_MRHO, S_SQ, S_RATIO, S_BASE,
    S_KX, S_TX1, S_TX2, S_KY, S_TY1, S_TY2,
    S_KV, S_VX1, S_VX2, S_VY1, S_VY2, S_OX, S_OY
  } step_e;

  state_e state_q;
  step_e  step_q, nstep;
  state_e nstate;

  spf_pkg::item_t     it_q;
  logic signed [31:0] own_px_q, own_py_q, own_vx_q, own_vy_q, own_p_q;
  logic signed [63:0] spx_q, spy_q, svx_q, svy_q;
  logic               sing_q;
  logic [30:0]        q_q;
  logic signed [31:0] mrho_q, ratio_q, base_q, k_q, t_q, kv_q, ovx_q, ovy_q;
  logic signed [63:0] p_q;
  logic               div_go_q;
  spf_pkg::result_t   res_q;
  logic               res_v_q;

  logic signed [31:0] op_a, op_b, r, omq, avg, dx, dy, dvx, dvy, quo_sat;
  logic signed [32:0] omq_w, sum_p, d_x, d_y, d_vx, d_vy;
  logic               take, out_free;

  assign omq_w = $signed({2'b00, ONE31}) - $signed({2'b00, q_q});
  assign omq   = omq_w[31:0];
  assign sum_p = {own_p_q[31], own_p_q} + {it_q.pressure[31], it_q.pressure};
  assign avg   = sum_p[32:1];
  assign d_x   = {own_px_q[31], own_px_q} - {it_q.pos_x[31], it_q.pos_x};
  assign d_y   = {own_py_q[31], own_py_q} - {it_q.pos_y[31], it_q.pos_y};
  assign d_vx  = {own_vx_q[31], own_vx_q} - {it_q.vel_x[31], it_q.vel_x};
  assign d_vy  = {own_vy_q[31], own_vy_q} - {it_q.vel_y[31], it_q.vel_y};
  assign dx    = spf_pkg::sat32(64'(d_x));
  assign dy    = spf_pkg::sat32(64'(d_y));
  assign dvx   = spf_pkg::sat32(64'(d_vx));
  assign dvy   = spf_pkg::sat32(64'(d_vy));

  // product back to Q format, floor then saturate
  assign r = spf_pkg::sat32(p_q >>> FRAC_BITS);
  assign quo_sat = (|div_quo_i[NUM_W-1:31]) ? spf_pkg::MAX32 : {1'b0, div_quo_i[30:0]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      S_Q:    begin op_a = {1'b0, it_q.distance}; op_b = {1'b0, cfg_i.inv_radius}; end
      S_SQ:   begin op_a = omq;                op_b = omq;     end
      S_BASE: begin op_a = mrho_q;             op_b = avg;     end
      S_KX:   begin op_a = {1'b0, cfg_i.kp};   op_b = dx;      end
      S_KY:   begin op_a = {1'b0, cfg_i.kp};   op_b = dy;      end
      S_TX1,
      S_TY1:  begin op_a = base_q;             op_b = k_q;     end
      S_TX2,
      S_TY2:  begin op_a = t_q;                op_b = ratio_q; end
      S_KV:   begin op_a = {1'b0, cfg_i.kv};   op_b = omq;     end
      S_VX1:  begin op_a = mrho_q;             op_b = dvx;     end
      S_VY1:  begin op_a = mrho_q;             op_b = dvy;     end
      S_VX2,
      S_VY2:  begin op_a = t_q;                op_b = kv_q;    end
      S_OX:   begin op_a = {1'b0, cfg_i.mu};   op_b = spf_pkg::sat32(svx_q); end
      S_OY:   begin op_a = {1'b0, cfg_i.mu};   op_b = spf_pkg::sat32(svy_q); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    if (step_q == S_RATIO) begin
      div_num_o = {t_q[30:0], {FRAC_BITS{1'b0}}};
      div_den_o = q_q;
    end else begin
      div_num_o = {cfg_i.mass, {FRAC_BITS{1'b0}}};
      div_den_o = it_q.density;
    end
  end

  // sequence of steps; a zero q skips the pressure terms
  always_comb begin
    nstep = step_q;
    case (step_q)
      S_Q:     nstep = S_MRHO;
      S_MRHO:  nstep = (q_q == '0) ? S_KV : S_SQ;
      S_SQ:    nstep = S_RATIO;
      S_RATIO: nstep = S_BASE;
      S_BASE:  nstep = S_KX;
      S_KX:    nstep = S_TX1;
      S_TX1:   nstep = S_TX2;
      S_TX2:   nstep = S_KY;
      S_KY:    nstep = S_TY1;
      S_TY1:   nstep = S_TY2;
      S_TY2:   nstep = S_KV;
      S_KV:    nstep = S_VX1;
      S_VX1:   nstep = S_VX2;
      S_VX2:   nstep = S_VY1;
      S_VY1:   nstep = S_VY2;
      S_VY2:   nstep = S_OX;
      S_OX:    nstep = S_OY;
      S_OY:    nstep = S_OY;
      default: nstep = S_Q;
    endcase
    if (step_q == S_OY) nstate = ST_OUT;
    else if (step_q == S_VY2 && !it_q.last) nstate = ST_IDLE;
    else if (nstep == S_MRHO || nstep == S_RATIO) nstate = ST_DIV;
    else nstate = ST_MUL;
  end

  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_valid_i && item_ready_o;
  assign div_start_o  = (state_q == ST_DIV) && !div_go_q;
  assign out_free     = !res_v_q || res_pop_i;
  assign res_o        = res_q;
  assign res_valid_o  = res_v_q;

  always_ff @(posedge clk_i) begin
    if (take) it_q <= item_i;
    if (state_q == ST_MUL) p_q <= op_a * op_b;
    if (state_q == ST_WB) begin
      case (step_q)
        S_Q:    q_q    <= r[30:0];
        S_SQ:   t_q    <= r;
        S_BASE: base_q <= r;
        S_KX,
        S_KY:   k_q    <= r;
        S_TX1,
        S_TY1,
        S_VX1,
        S_VY1:  t_q    <= r;
        S_KV:   kv_q   <= r;
        S_OX:   ovx_q  <= spf_pkg::neg_sat(r);
        S_OY:   ovy_q  <= spf_pkg::neg_sat(r);
        default: ;
      endcase
    end
    if (state_q == ST_DIV && div_done_i) begin
      if (step_q == S_RATIO) ratio_q <= quo_sat;
      else mrho_q <= quo_sat;
    end
    if (state_q == ST_OUT && out_free) begin
      res_q.fpx      <= spf_pkg::neg_sat(spf_pkg::sat32(spx_q));
      res_q.fpy      <= spf_pkg::neg_sat(spf_pkg::sat32(spy_q));
      res_q.fvx      <= ovx_q;
      res_q.fvy      <= ovy_q;
      res_q.singular <= sing_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= S_Q;
      div_go_q <= 1'b0;
      res_v_q  <= 1'b0;
      own_px_q <= '0;
      own_py_q <= '0;
      own_vx_q <= '0;
      own_vy_q <= '0;
      own_p_q  <= '0;
      spx_q    <= '0;
      spy_q    <= '0;
      svx_q    <= '0;
      svy_q    <= '0;
      sing_q   <= 1'b0;
    end else begin
      // the result register is reloaded in ST_OUT, cleared on a pop otherwise
      if (res_v_q && res_pop_i && state_q != ST_OUT) res_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            if (!item_i.is_nbr) begin
              own_px_q <= item_i.pos_x;
              own_py_q <= item_i.pos_y;
              own_vx_q <= item_i.vel_x;
              own_vy_q <= item_i.vel_y;
              own_p_q  <= item_i.pressure;
              spx_q    <= '0;
              spy_q    <= '0;
              svx_q    <= '0;
              svy_q    <= '0;
              sing_q   <= 1'b0;
              step_q   <= S_OX;
              state_q  <= item_i.last ? ST_MUL : ST_IDLE;
            end else begin
              step_q  <= S_Q;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: state_q <= ST_WB;
        ST_WB: begin
          case (step_q)
            S_TX2: spx_q <= spf_pkg::acc64(spx_q, r);
            S_TY2: spy_q <= spf_pkg::acc64(spy_q, r);
            S_VX2: svx_q <= spf_pkg::acc64(svx_q, r);
            S_VY2: svy_q <= spf_pkg::acc64(svy_q, r);
            default: ;
          endcase
          step_q  <= nstep;
          state_q <= nstate;
        end
        ST_DIV: begin
          if (div_start_o) div_go_q <= 1'b1;
          if (div_done_i) begin
            div_go_q <= 1'b0;
            if (step_q == S_MRHO && q_q == '0) sing_q <= 1'b1;
            step_q  <= nstep;
            state_q <= nstate;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res_v_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == ST_DIV)) else $error("divider finished outside a divide step");
  a_out_only_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> it_q.last) else $error("result built for an item without last");
  a_sums_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !take) |=> $stable(spx_q) && $stable(svy_q))
    else $error("sums changed while idle");
`endif

endmodule

// ===== hdl/sph_pair_force_accumulator.sv =====
// Top level of the SPH pair force accumulator: config registers, front end, back end, divider.
// A start transaction (func 0) loads the particle's own position, velocity and pressure and
// clears the four force sums and the singular flag; each neighbour transaction (func 1) adds
// the pressure and viscous terms of one pair in signed fixed point with FRAC_BITS fraction
// bits; a transaction flagged last yields one result with the negated pressure sums, the
// viscous sums scaled by minus the viscosity, and the singular flag (a neighbour at zero
// normalised distance, whose pressure terms are then left out). Both sides look like a
// queue: push/full in, empty/pop out. A two-entry input queue lets the next transactions be
// pushed while one is worked on, and a result register holds a finished result until popped
// while the next transaction proceeds. One neighbour with non-zero q makes fourteen passes
// through the shared 32x32 multiplier and two divisions through the bit-serial divider at
// one quotient bit per cycle; a zero q saves eight products and one division. A last flag
// adds two more products and a step that loads the result; a start transaction without
// last returns straight to idle. Values are Q16.16 with the default FRAC_BITS. Configuration
// writes take effect at once and must only be made while no transaction is in progress.
module sph_pair_force_accumulator #(
  parameter int unsigned FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] pressure_i,
  input  logic [30:0] density_i,
  input  logic [30:0] distance_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] force_pressure_x_o,
  output logic [31:0] force_pressure_y_o,
  output logic [31:0] force_viscous_x_o,
  output logic [31:0] force_viscous_y_o,
  output logic        singular_o
);

  localparam int unsigned NUM_W = 31 + FRAC_BITS;
  localparam logic [30:0] ONE31 = 31'(1) << FRAC_BITS;

  spf_pkg::cfg_t    cfg_q;
  spf_pkg::item_t   item;
  logic             item_valid, item_ready;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [30:0]      div_den;
  spf_pkg::result_t res;
  logic             res_valid;

  // config registers; indices past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mass       <= ONE31;
      cfg_q.inv_radius <= ONE31;
      cfg_q.kp         <= ONE31;
      cfg_q.kv         <= ONE31;
      cfg_q.mu         <= ONE31;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spf_pkg::CFG_MASS:       cfg_q.mass       <= cfg_data_i;
        spf_pkg::CFG_INV_RADIUS: cfg_q.inv_radius <= cfg_data_i;
        spf_pkg::CFG_KP:         cfg_q.kp         <= cfg_data_i;
        spf_pkg::CFG_KV:         cfg_q.kv         <= cfg_data_i;
        spf_pkg::CFG_VISCOSITY:  cfg_q.mu         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .pressure_i   (pressure_i),
    .density_i    (density_i),
    .distance_i   (distance_i),
    .last_i       (last_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  spf_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  spf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .div_start_o  (div_start),
    .div_num_o    (div_num),
    .div_den_o    (div_den),
    .div_done_i   (div_done),
    .div_quo_i    (div_quo),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop)
  );

  assign empty              = !res_valid;
  assign force_pressure_x_o = res.fpx;
  assign force_pressure_y_o = res.fpy;
  assign force_viscous_x_o  = res.fvx;
  assign force_viscous_y_o  = res.fvy;
  assign singular_o         = res.singular;

endmodule
